/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked at every edge, reset included
`define ASSERT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rcw_pkg.sv */
// ----------------------------------------------------------------------------
// rcw_pkg
// Types and codes for the Q16.16 range counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 3;

  // Item kinds
  localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
  localparam logic [KindW-1:0] KIND_SET   = 2'd1;
  localparam logic [KindW-1:0] KIND_RESET = 2'd2;

  // Counting modes
  localparam logic [ModeW-1:0] MODE_WRAP_UP   = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRAP_DOWN = 2'd1;
  localparam logic [ModeW-1:0] MODE_PP_UP     = 2'd2;
  localparam logic [ModeW-1:0] MODE_PP_DOWN   = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd3;

  // Reset values
  localparam logic signed [DataW-1:0] LOW_RST  = 32'sd0;
  localparam logic signed [DataW-1:0] HIGH_RST = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] STEP_RST = 32'sd65536;

  typedef struct packed {
    logic signed [DataW-1:0] low;
    logic signed [DataW-1:0] high;
    logic signed [DataW-1:0] step;
    logic [ModeW-1:0]        mode;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] count;
    logic                    stage;
    logic                    done;
  } cnt_state_t;

endpackage

`default_nettype wire

/* rtl/rcw_cfg.sv */
// ----------------------------------------------------------------------------
// rcw_cfg
// Configuration register file: bounds, step and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [rcw_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [rcw_pkg::DataW-1:0]        cfg_data,
  output rcw_pkg::cfg_t                         cfg
);

  // Writes always taken; unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low  <= rcw_pkg::LOW_RST;
      cfg.high <= rcw_pkg::HIGH_RST;
      cfg.step <= rcw_pkg::STEP_RST;
      cfg.mode <= rcw_pkg::MODE_WRAP_UP;
    end else if (cfg_valid) begin
      case (cfg_index)
        rcw_pkg::REG_LOW:  cfg.low  <= cfg_data;
        rcw_pkg::REG_HIGH: cfg.high <= cfg_data;
        rcw_pkg::REG_STEP: cfg.step <= cfg_data;
        rcw_pkg::REG_MODE: cfg.mode <= cfg_data[rcw_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rcw_step.sv */
// ----------------------------------------------------------------------------
// rcw_step
// Next-state logic for one item: tick advance, set count or restart.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_step (
  input  wire logic [rcw_pkg::KindW-1:0]        kind,
  input  wire logic signed [rcw_pkg::DataW-1:0] value,
  input  wire rcw_pkg::cfg_t                    cfg,
  input  wire rcw_pkg::cnt_state_t              cur,
  output rcw_pkg::cnt_state_t                   nxt
);

  localparam int unsigned W  = rcw_pkg::DataW;
  localparam int unsigned SW = W + 2;

  logic signed [W-1:0]  lo;
  logic signed [W-1:0]  hi;
  logic                 neg;
  logic                 stage_eff;
  logic                 up;
  logic signed [SW-1:0] sum;
  logic signed [W-1:0]  sat;
  logic                 ge_hi;
  logic                 le_lo;
  logic signed [W-1:0]  set_val;
  rcw_pkg::cnt_state_t  tick_nxt;

  // Effective bounds, swapped if reversed
  always_comb begin
    if (cfg.low > cfg.high) begin
      lo = cfg.high;
      hi = cfg.low;
    end else begin
      lo = cfg.low;
      hi = cfg.high;
    end
  end

  // Direction: modes wrap-up and up-then-down count up; ping-pong modes flip in stage 1
  assign neg       = cfg.step[W-1];
  assign stage_eff = cur.stage & cfg.mode[1];
  assign up        = ~cfg.mode[0] ^ stage_eff;

  // Exact sum, then saturate to 32 bits
  always_comb begin
    if (up) begin
      sum = {{2{cur.count[W-1]}}, cur.count} + {{2{cfg.step[W-1]}}, cfg.step};
    end else begin
      sum = {{2{cur.count[W-1]}}, cur.count} - {{2{cfg.step[W-1]}}, cfg.step};
    end
    if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
      sat = sum[W-1:0];
    end else if (sum[SW-1]) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  assign ge_hi = (sat >= hi);
  assign le_lo = (sat <= lo);

  // Bound handling by mode
  always_comb begin
    tick_nxt.count = sat;
    tick_nxt.stage = stage_eff;
    tick_nxt.done  = 1'b0;
    case (cfg.mode)
      rcw_pkg::MODE_WRAP_UP, rcw_pkg::MODE_WRAP_DOWN: begin
        if (cfg.mode[0] == neg) begin
          if (ge_hi) begin
            tick_nxt.count = lo;
            tick_nxt.done  = 1'b1;
          end
        end else if (le_lo) begin
          tick_nxt.count = hi;
          tick_nxt.done  = 1'b1;
        end
      end
      rcw_pkg::MODE_PP_UP: begin
        if (ge_hi) begin
          tick_nxt.count = hi;
          tick_nxt.stage = ~neg;
          tick_nxt.done  = 1'b1;
        end else if (le_lo) begin
          tick_nxt.count = lo;
          tick_nxt.stage = neg;
          tick_nxt.done  = 1'b1;
        end
      end
      default: begin
        if (ge_hi) begin
          tick_nxt.count = hi;
          tick_nxt.stage = neg;
          tick_nxt.done  = 1'b1;
        end else if (le_lo) begin
          tick_nxt.count = lo;
          tick_nxt.stage = ~neg;
          tick_nxt.done  = 1'b1;
        end
      end
    endcase
  end

  // Set count clamps against the raw bounds, low test first
  always_comb begin
    if (value < cfg.low) begin
      set_val = cfg.low;
    end else if (value > cfg.high) begin
      set_val = cfg.high;
    end else begin
      set_val = value;
    end
  end

  // Select by item kind
  always_comb begin
    nxt = cur;
    case (kind)
      rcw_pkg::KIND_TICK: nxt = tick_nxt;
      rcw_pkg::KIND_SET:  nxt.count = set_val;
      rcw_pkg::KIND_RESET: begin
        if (!cfg.mode[0] && !neg) begin
          nxt.count = cfg.low;
        end else begin
          nxt.count = cfg.high;
        end
        nxt.stage = 1'b0;
        nxt.done  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/range_counter_wrap_pingpong.sv */
// ----------------------------------------------------------------------------
// range_counter_wrap_pingpong
// Q16.16 range counter with wrap and ping-pong modes, signed step.
// ----------------------------------------------------------------------------
//  channel | signals                           | handshake
//  --------+-----------------------------------+------------------
//  in      | kind, count_value                 | in_valid/in_stall
//  out     | count_out, done_res               | out_valid/out_stall
//  cfg     | cfg_index, cfg_data               | cfg_valid/cfg_ready
//
//  One item per cycle sustained unless out_stall holds a tick. An item sits in
//  the input register until it goes on, when the counter state is updated; a
//  tick word lands in the output register at that same edge and is valid there.
//  Set and restart items make no word and never wait on the output side.
//  Sync reset clears valids and loads counter state (count 0, done armed).
//  out_stall holds a tick in the input register, which then stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module range_counter_wrap_pingpong (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rcw_pkg::KindW-1:0]        kind,
  input  wire logic signed [rcw_pkg::DataW-1:0] count_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [rcw_pkg::DataW-1:0]      count_out,
  output logic                                  done_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rcw_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [rcw_pkg::DataW-1:0]        cfg_data
);

  rcw_pkg::cfg_t                  cfg;
  rcw_pkg::cnt_state_t            state;
  rcw_pkg::cnt_state_t            state_next;
  logic                           item_vld;
  logic [rcw_pkg::KindW-1:0]      item_kind;
  logic signed [rcw_pkg::DataW-1:0] item_value;
  logic                           out_free;
  logic                           item_go;

  assign cfg_ready = 1'b1;

  rcw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcw_step u_step (
    .kind  (item_kind),
    .value (item_value),
    .cfg   (cfg),
    .cur   (state),
    .nxt   (state_next)
  );

  // Only ticks need room in the output register
  assign out_free = ~out_valid | ~out_stall;
  assign item_go  = item_vld & ((item_kind != rcw_pkg::KIND_TICK) | out_free);
  assign in_stall = item_vld & ~item_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!in_stall) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_kind  <= kind;
      item_value <= count_value;
    end
  end

  // Counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.count <= rcw_pkg::LOW_RST;
      state.stage <= 1'b0;
      state.done  <= 1'b1;
    end else if (item_go) begin
      state <= state_next;
    end
  end

  // Output register: pre-advance count and the armed done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_go & (item_kind == rcw_pkg::KIND_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      count_out <= state.count;
      done_res  <= state.done;
    end
  end

endmodule

`default_nettype wire

/* rtl/rcw_checker.sv */
// ----------------------------------------------------------------------------
// rcw_checker
// Port-level checks on the range counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rcw_pkg::DataW-1:0]   count_out,
  input wire logic                        done_res,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready
);

  logic out_wait;

  // result word waiting on the sink
  assign out_wait = out_valid && out_stall;

  // Input only backs up behind a stalled result word
  `ASSERT_IMP(a_stall_cause, clk, rst, in_stall, out_wait)

  // A stalled result word holds
  `ASSERT_NXT(a_out_hold, clk, rst, out_wait, out_valid && $stable({count_out, done_res}))

  // No word straight out of reset
  `ASSERT_ALL(a_rst_empty, clk, rst, ##1 (!out_valid && !in_stall))

  // Register writes are never refused
  `ASSERT_IMP(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind range_counter_wrap_pingpong rcw_checker u_rcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .count_out (count_out),
  .done_res  (done_res),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 range counter. Ticks, set-count and
// restart words are driven with random gaps, the output side stalls at
// random, and every tick word is checked against a software copy of the
// counter. Registers are reprogrammed between phases while the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rcw_pkg::KindW-1:0] KIND_SPARE = 2'd3;  // ignored by the block
  localparam int                 FIRST_SPARE_REG = 4;    // indexes above REG_MODE
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [33:0] SUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SUM_MIN = 34'sh3_8000_0000;
  localparam int                 SETTLE_CYCLES = 4;

  typedef struct {
    logic signed [rcw_pkg::DataW-1:0] count;
    logic                             done;
  } tick_word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [rcw_pkg::KindW-1:0]        kind = rcw_pkg::KIND_TICK;
  logic signed [rcw_pkg::DataW-1:0] count_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [rcw_pkg::DataW-1:0] count_out;
  logic                             done_res;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rcw_pkg::CfgIdxW-1:0]      cfg_index = rcw_pkg::REG_LOW;
  logic [rcw_pkg::DataW-1:0]        cfg_data = '0;

  // shadow copy of the counter
  rcw_pkg::cfg_t                    regs_shadow;
  logic signed [rcw_pkg::DataW-1:0] count_shadow;
  logic                             stage_shadow;
  logic                             done_shadow;

  tick_word_t pending_ticks[$];
  int         mismatches = 0;
  int         max_gap = 11;

  range_counter_wrap_pingpong dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .count_value(count_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count_out(count_out),
    .done_res(done_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register write as seen by the shadow
  function automatic void shadow_reg_write(logic [rcw_pkg::CfgIdxW-1:0] idx,
                                           logic [rcw_pkg::DataW-1:0] data);
    case (idx)
      rcw_pkg::REG_LOW:  regs_shadow.low  = data;
      rcw_pkg::REG_HIGH: regs_shadow.high = data;
      rcw_pkg::REG_STEP: regs_shadow.step = data;
      rcw_pkg::REG_MODE: regs_shadow.mode = data[rcw_pkg::ModeW-1:0];
      default: ;
    endcase
  endfunction

  // one tick: queue the word it emits, then move the count
  function automatic void shadow_tick();
    logic signed [rcw_pkg::DataW-1:0] lo, hi, swap_tmp, step, nxt;
    logic signed [33:0]               cur_w, step_w, sum;
    logic [rcw_pkg::ModeW-1:0]        mode;
    logic                             neg, down;
    tick_word_t                       word;
    lo = regs_shadow.low;
    hi = regs_shadow.high;
    step = regs_shadow.step;
    mode = regs_shadow.mode;
    neg = step < 0;
    if (lo > hi) begin
      swap_tmp = lo;
      lo = hi;
      hi = swap_tmp;
    end
    if (mode == rcw_pkg::MODE_WRAP_UP || mode == rcw_pkg::MODE_WRAP_DOWN) stage_shadow = 1'b0;
    down = (mode == rcw_pkg::MODE_WRAP_DOWN || mode == rcw_pkg::MODE_PP_DOWN) ^ stage_shadow;
    cur_w = count_shadow;
    step_w = step;
    sum = down ? cur_w - step_w : cur_w + step_w;
    if (sum > SUM_MAX) nxt = Q_MAX;
    else if (sum < SUM_MIN) nxt = Q_MIN;
    else nxt = sum[rcw_pkg::DataW-1:0];

    word.count = count_shadow;
    word.done = done_shadow;
    pending_ticks.push_back(word);
    done_shadow = 1'b0;

    case (mode)
      rcw_pkg::MODE_WRAP_UP, rcw_pkg::MODE_WRAP_DOWN: begin
        // top wrap for up with positive step or down with negative step
        if ((mode == rcw_pkg::MODE_WRAP_UP) != neg) begin
          if (nxt >= hi) begin
            nxt = lo;
            done_shadow = 1'b1;
          end
        end else if (nxt <= lo) begin
          nxt = hi;
          done_shadow = 1'b1;
        end
      end
      rcw_pkg::MODE_PP_UP: begin
        if (nxt >= hi) begin
          nxt = hi;
          stage_shadow = !neg;
          done_shadow = 1'b1;
        end else if (nxt <= lo) begin
          nxt = lo;
          stage_shadow = neg;
          done_shadow = 1'b1;
        end
      end
      default: begin
        if (nxt >= hi) begin
          nxt = hi;
          stage_shadow = neg;
          done_shadow = 1'b1;
        end else if (nxt <= lo) begin
          nxt = lo;
          stage_shadow = !neg;
          done_shadow = 1'b1;
        end
      end
    endcase
    count_shadow = nxt;
  endfunction

  // apply one accepted input word to the shadow
  function automatic void shadow_accept(logic [rcw_pkg::KindW-1:0] k,
                                        logic signed [rcw_pkg::DataW-1:0] v);
    logic signed [rcw_pkg::DataW-1:0] lo, hi;
    lo = regs_shadow.low;
    hi = regs_shadow.high;
    case (k)
      rcw_pkg::KIND_TICK: shadow_tick();
      rcw_pkg::KIND_SET: begin
        // raw bounds, lower test first
        if (v < lo) count_shadow = lo;
        else if (v > hi) count_shadow = hi;
        else count_shadow = v;
      end
      rcw_pkg::KIND_RESET: begin
        if ((regs_shadow.mode == rcw_pkg::MODE_WRAP_UP ||
             regs_shadow.mode == rcw_pkg::MODE_PP_UP) &&
            regs_shadow.step >= 0) count_shadow = lo;
        else count_shadow = hi;
        stage_shadow = 1'b0;
        done_shadow = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // drive one input word; valid stays up when the next word follows at once
  task automatic send_word(logic [rcw_pkg::KindW-1:0] k, logic signed [rcw_pkg::DataW-1:0] v);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    count_value <= v;
    do @(posedge clk); while (in_stall);
    shadow_accept(k, v);
  endtask

  // valid is left high; callers drop it once the writes are done
  task automatic write_reg(logic [rcw_pkg::CfgIdxW-1:0] idx, logic [rcw_pkg::DataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_reg_write(idx, data);
  endtask

  task automatic program_counter(logic signed [rcw_pkg::DataW-1:0] lo,
                                 logic signed [rcw_pkg::DataW-1:0] hi,
                                 logic signed [rcw_pkg::DataW-1:0] step,
                                 logic [rcw_pkg::ModeW-1:0] mode);
    write_reg(rcw_pkg::REG_LOW, lo);
    write_reg(rcw_pkg::REG_HIGH, hi);
    write_reg(rcw_pkg::REG_STEP, step);
    // upper data bits must not matter
    write_reg(rcw_pkg::REG_MODE, {(rcw_pkg::DataW-rcw_pkg::ModeW)'($urandom()), mode});
    cfg_valid <= 1'b0;
  endtask

  // idle until every tick word is back and the pipe is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // defaults straight out of reset, plus the unused kind
  task automatic test_reset_defaults();
    send_word(rcw_pkg::KIND_TICK, $urandom());
    send_word(rcw_pkg::KIND_TICK, $urandom());
    send_word(KIND_SPARE, $urandom());
    send_word(rcw_pkg::KIND_TICK, $urandom());
  endtask

  // swapped extreme bounds, most negative step, saturating sum
  task automatic test_extremes();
    settle();
    program_counter(Q_MAX, Q_MIN, Q_MIN, rcw_pkg::MODE_PP_DOWN);
    send_word(rcw_pkg::KIND_RESET, '0);
    send_word(rcw_pkg::KIND_SET, Q_MIN);
    send_word(rcw_pkg::KIND_TICK, '0);
    send_word(rcw_pkg::KIND_SET, Q_MAX);
    send_word(rcw_pkg::KIND_TICK, '0);
    send_word(rcw_pkg::KIND_TICK, '0);
  endtask

  // zero step: count holds but bound tests still fire
  task automatic test_zero_step();
    settle();
    program_counter(-32'sd65536, 32'sd65536, '0, rcw_pkg::MODE_WRAP_DOWN);
    send_word(rcw_pkg::KIND_RESET, '0);
    send_word(rcw_pkg::KIND_TICK, '0);
    send_word(rcw_pkg::KIND_SET, -32'sd65536);
    send_word(rcw_pkg::KIND_TICK, '0);
    send_word(rcw_pkg::KIND_TICK, '0);
  endtask

  // a mode write alone keeps the stage and done flag
  task automatic test_mode_switch();
    settle();
    program_counter('0, 32'sd196608, 32'sd65536, rcw_pkg::MODE_PP_UP);
    send_word(rcw_pkg::KIND_RESET, '0);
    repeat (4) send_word(rcw_pkg::KIND_TICK, '0);
    settle();
    write_reg(rcw_pkg::REG_MODE,
              {{(rcw_pkg::DataW-rcw_pkg::ModeW){1'b0}}, rcw_pkg::MODE_PP_DOWN});
    cfg_valid <= 1'b0;
    repeat (2) send_word(rcw_pkg::KIND_TICK, '0);
    send_word(rcw_pkg::KIND_RESET, '0);
    send_word(rcw_pkg::KIND_TICK, '0);
  endtask

  // random phases: fresh registers, usually a restart, then mostly ticks
  task automatic test_random_runs(int phases, int words_per_phase);
    logic signed [rcw_pkg::DataW-1:0] lo, hi, swap_tmp, step;
    logic                             wide;
    int                               sent, pick;
    for (int ph = 0; ph < phases; ph++) begin
      settle();
      max_gap = (ph % 5 == 4) ? 0 : 11;
      wide = 1'b0;
      case ($urandom_range(0, 4))
        0: begin
          lo = $urandom();
          hi = $urandom();
          wide = 1'b1;
        end
        1: begin
          lo = Q_MIN;
          hi = Q_MAX;
          wide = 1'b1;
        end
        default: begin
          lo = $urandom();
          hi = lo + $signed($urandom_range(1, 1 << 20));
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        swap_tmp = lo;
        lo = hi;
        hi = swap_tmp;
      end
      case ($urandom_range(0, 7))
        0: step = '0;
        1: step = $urandom();
        2: step = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        default: begin
          step = wide ? $urandom_range(1 << 26, 1 << 30) : $urandom_range(1, 1 << 18);
          if ($urandom_range(0, 1)) step = -step;
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(rcw_pkg::CfgIdxW'($urandom_range(FIRST_SPARE_REG, 7)), $urandom());
      program_counter(lo, hi, step, rcw_pkg::ModeW'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) != 0) send_word(rcw_pkg::KIND_RESET, $urandom());
      sent = 0;
      while (sent < words_per_phase) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_word(rcw_pkg::KIND_TICK, $urandom());
          sent++;
        end else if (pick < 88) begin
          send_word(rcw_pkg::KIND_SET,
                    $urandom_range(0, 1) ? $signed($urandom())
                                         : lo + $signed($urandom_range(0, 1 << 20)));
          sent++;
        end else if (pick < 94) begin
          send_word(rcw_pkg::KIND_RESET, $urandom());
          sent++;
        end else begin
          send_word(KIND_SPARE, $urandom());
        end
      end
    end
    max_gap = 11;
  endtask

  // output side: random stall before each word
  initial begin : out_stall_gen
    int n;
    wait (!rst);
    forever begin
      n = $urandom_range(0, max_gap);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // compare each tick word with the oldest expectation
  always @(posedge clk) begin : check_words
    tick_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        $error("unexpected word: count_out %0d done_res %0b", count_out, done_res);
        mismatches++;
      end else begin
        want = pending_ticks.pop_front();
        if (count_out !== want.count) begin
          $error("count_out expected %0d got %0d", want.count, count_out);
          mismatches++;
        end
        if (done_res !== want.done) begin
          $error("done_res expected %0b got %0b", want.done, done_res);
          mismatches++;
        end
      end
    end
  end

  initial begin : main
    regs_shadow.low = rcw_pkg::LOW_RST;
    regs_shadow.high = rcw_pkg::HIGH_RST;
    regs_shadow.step = rcw_pkg::STEP_RST;
    regs_shadow.mode = rcw_pkg::MODE_WRAP_UP;
    count_shadow = rcw_pkg::LOW_RST;
    stage_shadow = 1'b0;
    done_shadow = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extremes();
    test_zero_step();
    test_mode_switch();
    test_random_runs(30, 40);
    settle();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* range_counter_wrap_pingpong.f */
+incdir+rtl
rtl/rcw_pkg.sv
rtl/rcw_cfg.sv
rtl/rcw_step.sv
rtl/range_counter_wrap_pingpong.sv
rtl/rcw_checker.sv
verif/tb.sv
